// ===== src/cmfc_pkg.sv =====
// Shared types and constants of the cascaded flight controller.
package cmfc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned GainW = 25;
  localparam int unsigned FuncW = 4;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [FuncW-1:0] FUNC_POS_TGT  = 4'd0;
  localparam logic [FuncW-1:0] FUNC_TILT_TGT = 4'd1;
  localparam logic [FuncW-1:0] FUNC_ATT      = 4'd2;
  localparam logic [FuncW-1:0] FUNC_RATE     = 4'd3;
  localparam logic [FuncW-1:0] FUNC_POS      = 4'd4;
  localparam logic [FuncW-1:0] FUNC_VEL      = 4'd5;
  localparam logic [FuncW-1:0] FUNC_TICK_POS = 4'd6;
  localparam logic [FuncW-1:0] FUNC_TICK_XY  = 4'd7;
  localparam logic [FuncW-1:0] FUNC_TICK_RP  = 4'd8;
  localparam logic [FuncW-1:0] FUNC_PHASE    = 4'd9;

  localparam logic [CfgIdxW-1:0] REG_RATE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ANGLE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_XYPOS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_XYVEL = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ZPOS  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ZVEL  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_HOVER = 3'd6;

  localparam logic signed [DataW-1:0] VEL_LIMIT  = 32'sd131072;
  localparam logic signed [DataW-1:0] TILT_LIMIT = 32'sd45875;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic signed [DataW-1:0] val_a;
    logic signed [DataW-1:0] val_b;
    logic signed [DataW-1:0] val_c;
    logic signed [DataW-1:0] val_d;
  } in_beat_t;

  typedef struct packed {
    logic signed [DataW-1:0] thrust;
    logic signed [DataW-1:0] roll_torque;
    logic signed [DataW-1:0] pitch_torque;
    logic signed [DataW-1:0] yaw_torque;
  } out_beat_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [GainW-1:0]   data;
  } cfg_beat_t;

  function automatic logic [16:0] asin_tab(input logic [3:0] i);
    logic [16:0] r;
    unique case (i)
      4'd0: r = 17'd0;       4'd1: r = 17'd4099;   4'd2: r = 17'd8213;
      4'd3: r = 17'd12361;   4'd4: r = 17'd16560;  4'd5: r = 17'd20829;
      4'd6: r = 17'd25192;   4'd7: r = 17'd29676;  4'd8: r = 17'd34315;
      4'd9: r = 17'd39152;   4'd10: r = 17'd44245; 4'd11: r = 17'd49679;
      4'd12: r = 17'd55579;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [DataW+1:0] v);
    logic signed [DataW-1:0] r;
    if (v > 34'sd2147483647) r = 32'sh7fffffff;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else r = v[DataW-1:0];
    return r;
  endfunction

endpackage

// ===== src/cmfc_stream_if.sv =====
// Valid/ready channel interfaces of the flight controller.
interface cmfc_in_if;
  logic valid;
  logic ready;
  cmfc_pkg::in_beat_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cmfc_out_if;
  logic valid;
  logic ready;
  cmfc_pkg::out_beat_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cmfc_cfg_if;
  logic valid;
  logic ready;
  cmfc_pkg::cfg_beat_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== src/cmfc_serial_mul.sv =====
// Bit-serial multiplier of an unsigned gain by a signed error, with Q16.16 rounding and saturation.
module cmfc_serial_mul (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [cmfc_pkg::GainW-1:0] gain,
  input  logic signed [cmfc_pkg::DataW-1:0] err,
  output logic done,
  output logic signed [cmfc_pkg::DataW-1:0] prod
);
  localparam int unsigned AccW = cmfc_pkg::GainW + cmfc_pkg::DataW + 1;
  localparam logic signed [AccW-1:0] PosMax = AccW'(32'sh7fffffff);
  localparam logic signed [AccW-1:0] NegMin = AccW'(32'sh80000000);

  logic [cmfc_pkg::GainW-1:0] g_r, g_nxt;
  logic signed [AccW-1:0] acc_r, acc_nxt;
  logic signed [AccW-1:0] e_r, e_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic signed [AccW-1:0] rnd;

  always_comb begin
    g_nxt = g_r;
    acc_nxt = acc_r;
    e_nxt = e_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      g_nxt = gain;
      acc_nxt = '0;
      e_nxt = AccW'(err);
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // add one shifted partial product per gain bit
      if (g_r[0]) acc_nxt = acc_r + e_r;
      g_nxt = g_r >> 1;
      e_nxt = e_r <<< 1;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(cmfc_pkg::GainW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign rnd = (acc_r + AccW'(32768)) >>> 16;
  assign prod = (rnd > PosMax) ? 32'sh7fffffff :
                (rnd < NegMin) ? 32'sh80000000 :
                rnd[cmfc_pkg::DataW-1:0];
  assign done = done_r;

  always_ff @(posedge clk) begin
    g_r <= g_nxt;
    acc_r <= acc_nxt;
    e_r <= e_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end
endmodule

// ===== src/cascaded_multirate_flight_controller_core.sv =====
// Top level of the cascaded proportional multirotor flight controller.
//
//  channel | dir | beat contents                         | accepted when
//  in_     | in  | func, val_a..val_d                    | in_valid & in_ready
//  out_    | out | thrust, roll/pitch/yaw torque         | out_valid & out_ready
//  cfg_    | in  | register index, 25-bit gain           | cfg_valid & cfg_ready
//
// Store and phase beats take effect as they are accepted. A tick runs its
// loops one after the other through a single bit-serial multiplier and,
// for tilt, a restoring divider and an asin lookup. Reset clears the phase,
// all stored targets and measurements and loads the default gains. A stalled
// result holds in the output register; the next input beat is taken only
// once it has left.
module cascaded_multirate_flight_controller_core #(
  parameter int unsigned OUTER_DIVIDE  = 25,
  parameter int unsigned MIDDLE_DIVIDE = 5
) (
  input logic clk,
  input logic rst_n,
  cmfc_in_if.sink    in_ch,
  cmfc_out_if.source out_ch,
  cmfc_cfg_if.sink   cfg_ch
);
  localparam int unsigned PhW = $clog2(OUTER_DIVIDE + 1);
  localparam int unsigned MidW = $clog2(MIDDLE_DIVIDE + 1);
  localparam int unsigned DW = cmfc_pkg::DataW;
  localparam int unsigned GW = cmfc_pkg::GainW;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_LOAD  = 9'b000000010,
    ST_MUL   = 9'b000000100,
    ST_WAIT  = 9'b000001000,
    ST_DIV   = 9'b000010000,
    ST_ASIN  = 9'b000100000,
    ST_AMUL  = 9'b001000000,
    ST_NEXT  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  // Operation steps of one tick, run in this order, each skipped when unused.
  typedef enum logic [3:0] {
    OP_VX, OP_VY, OP_AX, OP_AY, OP_TROLL, OP_TPITCH, OP_VZ,
    OP_RR, OP_RP, OP_RY, OP_TR, OP_TP, OP_TY, OP_UF, OP_END
  } op_t;

  state_t state_r, state_nxt;
  op_t op_r, op_nxt;

  logic [GW-1:0] gain_r [7];
  logic [PhW-1:0] phase_r;
  logic [MidW-1:0] mid_r;
  logic [cmfc_pkg::FuncW-1:0] func_r;

  logic signed [DW-1:0] ptgt_r [4];
  logic signed [DW-1:0] vref_r [3];
  logic signed [DW-1:0] tilt_r [2];
  logic signed [DW-1:0] rref_r [3];
  logic signed [DW-1:0] att_r [3];
  logic signed [DW-1:0] brate_r [3];
  logic signed [DW-1:0] pos_r [3];
  logic signed [DW-1:0] vel_r [3];
  logic signed [DW-1:0] ax_r, ay_r;
  logic signed [DW-1:0] tr_r, tp_r, ty_r;

  cmfc_pkg::out_beat_t obuf_r;
  logic ovalid_r;

  // divider: magnitude of accel*2^16 over hover, one quotient bit a cycle
  logic [47:0] dnum_r;
  logic [48:0] drem_r;
  logic [5:0] dcnt_r;
  logic dneg_r;
  logic [24:0] dden;

  // asin interpolation working values
  logic [16:0] abase_r;
  logic [14:0] adelta_r;
  logic [26:0] aprod_r;
  logic [3:0] acnt_r;
  logic [11:0] afrac_r;

  logic mstart;
  logic mdone;
  logic signed [DW-1:0] mprod;
  logic [GW-1:0] mgain;
  logic signed [DW-1:0] merr;
  logic signed [DW-1:0] mref, mmeas;

  logic outer, middle, tick_xy, do_op;
  logic in_take;

  assign outer = (phase_r == '0);
  assign middle = (mid_r == '0);
  assign tick_xy = (func_r != cmfc_pkg::FUNC_TICK_RP);

  always_comb begin
    unique case (op_r)
      OP_VX, OP_VY: do_op = tick_xy && outer;
      OP_AX, OP_AY, OP_TROLL, OP_TPITCH: do_op = tick_xy && middle;
      OP_VZ: do_op = (func_r == cmfc_pkg::FUNC_TICK_POS) && middle;
      OP_RR, OP_RP, OP_RY: do_op = middle;
      default: do_op = 1'b1;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mgain = gain_r[cmfc_pkg::REG_RATE];
    mref = '0;
    mmeas = '0;
    unique case (op_r)
      OP_VX: begin mgain = gain_r[cmfc_pkg::REG_XYPOS]; mref = ptgt_r[0]; mmeas = pos_r[0]; end
      OP_VY: begin mgain = gain_r[cmfc_pkg::REG_XYPOS]; mref = ptgt_r[1]; mmeas = pos_r[1]; end
      OP_AX: begin mgain = gain_r[cmfc_pkg::REG_XYVEL]; mref = vref_r[0]; mmeas = vel_r[0]; end
      OP_AY: begin mgain = gain_r[cmfc_pkg::REG_XYVEL]; mref = vref_r[1]; mmeas = vel_r[1]; end
      OP_VZ: begin mgain = gain_r[cmfc_pkg::REG_ZPOS]; mref = ptgt_r[2]; mmeas = pos_r[2]; end
      OP_RR: begin mgain = gain_r[cmfc_pkg::REG_ANGLE]; mref = tilt_r[0]; mmeas = att_r[0]; end
      OP_RP: begin mgain = gain_r[cmfc_pkg::REG_ANGLE]; mref = tilt_r[1]; mmeas = att_r[1]; end
      OP_RY: begin mgain = gain_r[cmfc_pkg::REG_ANGLE]; mref = ptgt_r[3]; mmeas = att_r[2]; end
      OP_TR: begin mref = rref_r[0]; mmeas = brate_r[0]; end
      OP_TP: begin mref = rref_r[1]; mmeas = brate_r[1]; end
      OP_TY: begin mref = rref_r[2]; mmeas = brate_r[2]; end
      OP_UF: begin mgain = gain_r[cmfc_pkg::REG_ZVEL]; mref = vref_r[2]; mmeas = vel_r[2]; end
      default: ;
    endcase
  end

  assign merr = cmfc_pkg::sat32(34'(mref) - 34'(mmeas));
  assign mstart = (state_r == ST_LOAD);

  cmfc_serial_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .gain(mgain), .err(merr),
    .done(mdone), .prod(mprod)
  );

  assign dden = (gain_r[cmfc_pkg::REG_HOVER] == '0) ? 25'd1 : gain_r[cmfc_pkg::REG_HOVER];

  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && !ovalid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = obuf_r;

  // next op: the step after the current one
  function automatic op_t op_inc(input op_t o);
    return op_t'(o + 4'd1);
  endfunction

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take && (in_ch.data.func == cmfc_pkg::FUNC_TICK_POS ||
                        in_ch.data.func == cmfc_pkg::FUNC_TICK_XY ||
                        in_ch.data.func == cmfc_pkg::FUNC_TICK_RP)) begin
          state_nxt = ST_NEXT;
          op_nxt = OP_VX;
        end
      end
      ST_NEXT: begin
        if (op_r == OP_END) state_nxt = ST_OUT;
        else if (!do_op) op_nxt = op_inc(op_r);
        else if (op_r == OP_TROLL || op_r == OP_TPITCH) state_nxt = ST_DIV;
        else state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_MUL;
      ST_MUL: if (mdone) state_nxt = ST_WAIT;
      ST_WAIT: begin
        state_nxt = ST_NEXT;
        op_nxt = op_inc(op_r);
      end
      // 48 restoring steps, counted 0..47
      ST_DIV: if (dcnt_r == 6'd47) state_nxt = ST_ASIN;
      ST_ASIN: state_nxt = ST_AMUL;
      ST_AMUL: if (acnt_r == 4'd0) begin
        state_nxt = ST_NEXT;
        op_nxt = op_inc(op_r);
      end
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // signed accel for the current tilt step (roll uses ay, pitch uses -ax)
  logic signed [DW:0] acc_sel;
  assign acc_sel = (op_r == OP_TROLL) ? (DW+1)'(ay_r) : -(DW+1)'(ax_r);

  // after division: clamp quotient magnitude, split into index and fraction
  logic [47:0] qmag;
  logic [15:0] qclamp;
  assign qmag = dnum_r;
  assign qclamp = (qmag > 48'(cmfc_pkg::TILT_LIMIT)) ? 16'(cmfc_pkg::TILT_LIMIT) : qmag[15:0];

  logic [16:0] asin_val;
  assign asin_val = abase_r + 17'((aprod_r + 27'd2048) >> 12);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r <= OP_VX;
      phase_r <= '0;
      mid_r <= '0;
      ovalid_r <= 1'b0;
      gain_r[0] <= 25'd32768;
      gain_r[1] <= 25'd327680;
      gain_r[2] <= 25'd39322;
      gain_r[3] <= 25'd327680;
      gain_r[4] <= 25'd65536;
      gain_r[5] <= 25'd65536;
      gain_r[6] <= 25'd1561733;
      for (int i = 0; i < 4; i++) ptgt_r[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        vref_r[i] <= '0; rref_r[i] <= '0; att_r[i] <= '0;
        brate_r[i] <= '0; pos_r[i] <= '0; vel_r[i] <= '0;
      end
      tilt_r[0] <= '0;
      tilt_r[1] <= '0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      if (cfg_ch.valid && cfg_ch.data.index <= cmfc_pkg::REG_HOVER)
        gain_r[cfg_ch.data.index] <= cfg_ch.data.data;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;

      if (in_take) begin
        func_r <= in_ch.data.func;
        unique case (in_ch.data.func)
          cmfc_pkg::FUNC_POS_TGT: begin
            ptgt_r[0] <= in_ch.data.val_a; ptgt_r[1] <= in_ch.data.val_b;
            ptgt_r[2] <= in_ch.data.val_c; ptgt_r[3] <= in_ch.data.val_d;
          end
          cmfc_pkg::FUNC_TILT_TGT: begin
            tilt_r[0] <= in_ch.data.val_a; tilt_r[1] <= in_ch.data.val_b;
            vref_r[2] <= in_ch.data.val_c;
          end
          cmfc_pkg::FUNC_ATT: begin
            att_r[0] <= in_ch.data.val_a; att_r[1] <= in_ch.data.val_b;
            att_r[2] <= in_ch.data.val_c;
          end
          cmfc_pkg::FUNC_RATE: begin
            brate_r[0] <= in_ch.data.val_a; brate_r[1] <= in_ch.data.val_b;
            brate_r[2] <= in_ch.data.val_c;
          end
          cmfc_pkg::FUNC_POS: begin
            pos_r[0] <= in_ch.data.val_a; pos_r[1] <= in_ch.data.val_b;
            pos_r[2] <= in_ch.data.val_c;
          end
          cmfc_pkg::FUNC_VEL: begin
            vel_r[0] <= in_ch.data.val_a; vel_r[1] <= in_ch.data.val_b;
            vel_r[2] <= in_ch.data.val_c;
          end
          cmfc_pkg::FUNC_PHASE: begin
            phase_r <= '0;
            mid_r <= '0;
          end
          default: ;
        endcase
      end

      // latch each product but the last (thrust) into its destination
      if (state_r == ST_WAIT) begin
        unique case (op_r)
          OP_VX: vref_r[0] <= (mprod > cmfc_pkg::VEL_LIMIT) ? cmfc_pkg::VEL_LIMIT :
                              (mprod < -cmfc_pkg::VEL_LIMIT) ? -cmfc_pkg::VEL_LIMIT : mprod;
          OP_VY: vref_r[1] <= (mprod > cmfc_pkg::VEL_LIMIT) ? cmfc_pkg::VEL_LIMIT :
                              (mprod < -cmfc_pkg::VEL_LIMIT) ? -cmfc_pkg::VEL_LIMIT : mprod;
          OP_AX: ax_r <= mprod;
          OP_AY: ay_r <= mprod;
          OP_VZ: vref_r[2] <= mprod;
          OP_RR: rref_r[0] <= mprod;
          OP_RP: rref_r[1] <= mprod;
          OP_RY: rref_r[2] <= mprod;
          OP_TR: tr_r <= mprod;
          OP_TP: tp_r <= mprod;
          OP_TY: ty_r <= mprod;
          default: ;
        endcase
      end

      // tilt conversion results
      if (state_r == ST_AMUL && acnt_r == 4'd0) begin
        if (op_r == OP_TROLL)
          tilt_r[0] <= dneg_r ? -DW'(asin_val) : DW'(asin_val);
        else
          tilt_r[1] <= dneg_r ? -DW'(asin_val) : DW'(asin_val);
      end

      // thrust and result beat; advance phase
      if (state_r == ST_OUT) begin
        obuf_r.thrust <= (gain_r[cmfc_pkg::REG_HOVER] == '0) ?
                         cmfc_pkg::sat32(-34'(mprod)) :
                         cmfc_pkg::sat32(34'(gain_r[cmfc_pkg::REG_HOVER]) - 34'(mprod));
        obuf_r.roll_torque <= tr_r;
        obuf_r.pitch_torque <= tp_r;
        obuf_r.yaw_torque <= ty_r;
        ovalid_r <= 1'b1;
        phase_r <= (phase_r == PhW'(OUTER_DIVIDE - 1)) ? '0 : phase_r + PhW'(1);
        mid_r <= (phase_r == PhW'(OUTER_DIVIDE - 1) || mid_r == MidW'(MIDDLE_DIVIDE - 1)) ?
                 '0 : mid_r + MidW'(1);
      end
    end
  end

  // divider and asin datapath: payload only
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_NEXT: begin
        dneg_r <= acc_sel[DW];
        dnum_r <= {(acc_sel[DW] ? 32'(-acc_sel) : 32'(acc_sel)), 16'd0};
        drem_r <= '0;
        dcnt_r <= '0;
      end
      ST_DIV: begin
        // restoring step: shift one numerator bit in, try subtract
        if ({drem_r[47:0], dnum_r[47]} >= 49'(dden)) begin
          drem_r <= {drem_r[47:0], dnum_r[47]} - 49'(dden);
          dnum_r <= {dnum_r[46:0], 1'b1};
        end else begin
          drem_r <= {drem_r[47:0], dnum_r[47]};
          dnum_r <= {dnum_r[46:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 6'd1;
      end
      ST_ASIN: begin
        abase_r <= cmfc_pkg::asin_tab(qclamp[15:12]);
        adelta_r <= 15'(cmfc_pkg::asin_tab(qclamp[15:12] + 4'd1) -
                        cmfc_pkg::asin_tab(qclamp[15:12]));
        afrac_r <= qclamp[11:0];
        aprod_r <= '0;
        acnt_r <= 4'd12;
      end
      ST_AMUL: begin
        // shift-add of delta by the 12-bit fraction, msb first
        if (acnt_r != 4'd0) begin
          aprod_r <= (aprod_r << 1) + (afrac_r[11] ? 27'(adelta_r) : 27'd0);
          afrac_r <= afrac_r << 1;
          acnt_r <= acnt_r - 4'd1;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench of the cascaded proportional flight controller core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts the controller outputs from the accepted beats and checks results.
  class flight_scoreboard;
    longint gain[7];
    int unsigned phase;
    longint pos_tgt[4];
    longint vel_ref[3];
    longint tilt_ref[2];
    longint rate_ref[3];
    longint att[3];
    longint brate[3];
    longint pos[3];
    longint vel[3];
    longint asin_lut[13];
    cmfc_pkg::out_beat_t pending[$];
    int unsigned mismatches;

    function new();
      asin_lut = '{0, 4099, 8213, 12361, 16560, 20829, 25192,
                   29676, 34315, 39152, 44245, 49679, 55579};
      gain = '{32768, 327680, 39322, 327680, 65536, 65536, 1561733};
      phase = 0;
      foreach (pos_tgt[i]) pos_tgt[i] = 0;
      foreach (vel_ref[i]) begin
        vel_ref[i] = 0; rate_ref[i] = 0; att[i] = 0;
        brate[i] = 0; pos[i] = 0; vel[i] = 0;
      end
      tilt_ref[0] = 0;
      tilt_ref[1] = 0;
      mismatches = 0;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint limit(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // Q16.16 product, rounded half up then floored, saturated.
    function longint scale(longint g, longint ref_v, longint meas_v);
      longint err;
      err = clip32(ref_v - meas_v);
      return clip32((g * err + 32768) >>> 16);
    endfunction

    function longint tilt(longint accel, longint hover);
      longint q, a, idx, frac, r;
      q = limit((accel * 65536) / hover, longint'(cmfc_pkg::TILT_LIMIT));
      a = (q < 0) ? -q : q;
      idx = a >>> 12;
      frac = a & 4095;
      r = asin_lut[idx] + (((asin_lut[idx+1] - asin_lut[idx]) * frac + 2048) >>> 12);
      return (q < 0) ? -r : r;
    endfunction

    function void write_reg(logic [cmfc_pkg::CfgIdxW-1:0] idx,
                            logic [cmfc_pkg::GainW-1:0] val);
      if (idx <= cmfc_pkg::REG_HOVER) gain[idx] = longint'(val);
    endfunction

    function void note_beat(cmfc_pkg::in_beat_t b);
      longint va, vb, vc, vd, hover, ax, ay, uf, thr;
      bit outer, middle;
      cmfc_pkg::out_beat_t r;
      va = longint'(b.val_a); vb = longint'(b.val_b);
      vc = longint'(b.val_c); vd = longint'(b.val_d);
      case (b.func)
        cmfc_pkg::FUNC_POS_TGT: begin
          pos_tgt[0] = va; pos_tgt[1] = vb; pos_tgt[2] = vc; pos_tgt[3] = vd;
        end
        cmfc_pkg::FUNC_TILT_TGT: begin
          tilt_ref[0] = va; tilt_ref[1] = vb; vel_ref[2] = vc;
        end
        cmfc_pkg::FUNC_ATT: begin att[0] = va; att[1] = vb; att[2] = vc; end
        cmfc_pkg::FUNC_RATE: begin brate[0] = va; brate[1] = vb; brate[2] = vc; end
        cmfc_pkg::FUNC_POS: begin pos[0] = va; pos[1] = vb; pos[2] = vc; end
        cmfc_pkg::FUNC_VEL: begin vel[0] = va; vel[1] = vb; vel[2] = vc; end
        cmfc_pkg::FUNC_PHASE: phase = 0;
        cmfc_pkg::FUNC_TICK_POS, cmfc_pkg::FUNC_TICK_XY, cmfc_pkg::FUNC_TICK_RP: begin
          outer = (phase % 25) == 0;
          middle = (phase % 5) == 0;
          hover = (gain[cmfc_pkg::REG_HOVER] == 0) ? 1 : gain[cmfc_pkg::REG_HOVER];
          if (b.func != cmfc_pkg::FUNC_TICK_RP) begin
            if (outer) begin
              vel_ref[0] = limit(scale(gain[cmfc_pkg::REG_XYPOS], pos_tgt[0], pos[0]),
                                 longint'(cmfc_pkg::VEL_LIMIT));
              vel_ref[1] = limit(scale(gain[cmfc_pkg::REG_XYPOS], pos_tgt[1], pos[1]),
                                 longint'(cmfc_pkg::VEL_LIMIT));
            end
            if (middle) begin
              ax = scale(gain[cmfc_pkg::REG_XYVEL], vel_ref[0], vel[0]);
              ay = scale(gain[cmfc_pkg::REG_XYVEL], vel_ref[1], vel[1]);
              tilt_ref[0] = tilt(ay, hover);
              tilt_ref[1] = tilt(-ax, hover);
            end
          end
          if (b.func == cmfc_pkg::FUNC_TICK_POS && middle)
            vel_ref[2] = scale(gain[cmfc_pkg::REG_ZPOS], pos_tgt[2], pos[2]);
          if (middle) begin
            rate_ref[0] = scale(gain[cmfc_pkg::REG_ANGLE], tilt_ref[0], att[0]);
            rate_ref[1] = scale(gain[cmfc_pkg::REG_ANGLE], tilt_ref[1], att[1]);
            rate_ref[2] = scale(gain[cmfc_pkg::REG_ANGLE], pos_tgt[3], att[2]);
          end
          r.roll_torque  = scale(gain[cmfc_pkg::REG_RATE], rate_ref[0], brate[0]);
          r.pitch_torque = scale(gain[cmfc_pkg::REG_RATE], rate_ref[1], brate[1]);
          r.yaw_torque   = scale(gain[cmfc_pkg::REG_RATE], rate_ref[2], brate[2]);
          uf = scale(gain[cmfc_pkg::REG_ZVEL], vel_ref[2], vel[2]);
          thr = (gain[cmfc_pkg::REG_HOVER] == 0) ? clip32(-uf) :
                clip32(gain[cmfc_pkg::REG_HOVER] - uf);
          r.thrust = thr;
          phase = (phase + 1 >= 25) ? 0 : phase + 1;
          pending.push_back(r);
        end
        default: ;  // unused codes are ignored
      endcase
    endfunction

    function void check_result(cmfc_pkg::out_beat_t got);
      cmfc_pkg::out_beat_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: thrust exp %0d got %0d, roll exp %0d got %0d, ",
                    "pitch exp %0d got %0d, yaw exp %0d got %0d"},
                   want.thrust, got.thrust, want.roll_torque, got.roll_torque,
                   want.pitch_torque, got.pitch_torque, want.yaw_torque, got.yaw_torque);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  int unsigned stall_left;
  int unsigned idle_cycles;
  flight_scoreboard sb;

  cmfc_in_if  in_ch();
  cmfc_out_if out_ch();
  cmfc_cfg_if cfg_ch();

  cascaded_multirate_flight_controller_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #10 clk = ~clk;

  // Drive the result ready in random stall bursts; hold it high once quiet.
  always @(negedge clk) begin
    if (quiet) begin
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Check every accepted result beat; count cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Mix full-range, extreme and small values so the loops leave saturation.
  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return 32'($urandom_range(0, 524288)) - 32'd262144;
    endcase
  endfunction

  task automatic send_beat(logic [cmfc_pkg::FuncW-1:0] fn, logic [31:0] a,
                           logic [31:0] b, logic [31:0] c, logic [31:0] d);
    int unsigned gap;
    // Insert an occasional idle burst ahead of the beat.
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = '{func: fn, val_a: a, val_b: b, val_c: c, val_d: d};
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    sb.note_beat(in_ch.data);
    @(negedge clk);
  endtask

  task automatic random_beat();
    logic [cmfc_pkg::FuncW-1:0] fn;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      fn = cmfc_pkg::FUNC_TICK_POS + cmfc_pkg::FuncW'($urandom_range(0, 2));
    else if (pick < 90) fn = cmfc_pkg::FuncW'($urandom_range(0, 5));
    else if (pick < 94) fn = cmfc_pkg::FUNC_PHASE;
    else fn = cmfc_pkg::FuncW'($urandom_range(10, 15));
    send_beat(fn, pick_val(), pick_val(), pick_val(), pick_val());
  endtask

  task automatic write_cfg(logic [cmfc_pkg::CfgIdxW-1:0] idx,
                           logic [cmfc_pkg::GainW-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = '{index: idx, data: val};
    forever begin
      @(posedge clk);
      if (cfg_ch.ready) break;
    end
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Drain all expected results, then allow a tick in flight to finish.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic load_gains(int unsigned style);
    logic [cmfc_pkg::GainW-1:0] v;
    for (int i = 0; i < 8; i++) begin
      case (style)
        0: v = cmfc_pkg::GainW'($urandom_range(0, 1 << 19));
        1: v = {cmfc_pkg::GainW{1'b1}};
        2: v = '0;
        default: v = cmfc_pkg::GainW'($urandom);
      endcase
      // Keep hover force in a realistic range on the random setting.
      if (style == 0 && i == cmfc_pkg::REG_HOVER)
        v = cmfc_pkg::GainW'($urandom_range(65536, 1 << 22));
      write_cfg(cmfc_pkg::CfgIdxW'(i), v);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    quiet = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b1;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats on reset gains: extremes, every function, unused codes.
    send_beat(cmfc_pkg::FUNC_TICK_POS, 0, 0, 0, 0);
    send_beat(cmfc_pkg::FUNC_POS_TGT, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000);
    send_beat(cmfc_pkg::FUNC_POS, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    send_beat(cmfc_pkg::FUNC_TICK_POS, 0, 0, 0, 0);
    send_beat(cmfc_pkg::FUNC_VEL, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    send_beat(cmfc_pkg::FUNC_ATT, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    send_beat(cmfc_pkg::FUNC_RATE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    send_beat(cmfc_pkg::FUNC_TICK_XY, 0, 0, 0, 0);
    send_beat(cmfc_pkg::FUNC_TICK_RP, 0, 0, 0, 0);
    send_beat(cmfc_pkg::FuncW'(10), 32'hffffffff, 32'hffffffff, 32'hffffffff,
              32'hffffffff);
    send_beat(cmfc_pkg::FuncW'(15), 0, 0, 0, 0);
    send_beat(cmfc_pkg::FUNC_PHASE, 0, 0, 0, 0);
    send_beat(cmfc_pkg::FUNC_TILT_TGT, 32'h00010000, 32'hffff0000, 32'h00020000, 0);
    send_beat(cmfc_pkg::FUNC_POS_TGT, 32'h00030000, 32'hfffd0000, 32'h00010000,
              32'h00008000);
    send_beat(cmfc_pkg::FUNC_POS, 0, 0, 0, 0);
    send_beat(cmfc_pkg::FUNC_VEL, 32'h00004000, 32'hffffc000, 0, 0);
    send_beat(cmfc_pkg::FUNC_TICK_POS, 0, 0, 0, 0);
    send_beat(cmfc_pkg::FUNC_TICK_XY, 0, 0, 0, 0);
    send_beat(cmfc_pkg::FUNC_TICK_RP, 0, 0, 0, 0);
    send_beat(cmfc_pkg::FUNC_TICK_POS, 0, 0, 0, 0);

    // Random phases under several gain settings; the last one runs without idling.
    for (int p = 0; p < 5; p++) begin
      drain();
      load_gains(p == 4 ? 0 : p);
      if (p == 4) quiet = 1'b1;
      for (int n = 0; n < 160; n++) random_beat();
    end

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/cmfc_pkg.sv
src/cmfc_stream_if.sv
src/cmfc_serial_mul.sv
src/cascaded_multirate_flight_controller_core.sv
verif/testbench.sv
